// File: design/undistort_rectify_map_unit_defines.svh
// Assertion macros shared by the undistort-rectify map unit.
`ifndef UNDISTORT_RECTIFY_MAP_UNIT_DEFINES_SVH
`define UNDISTORT_RECTIFY_MAP_UNIT_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define URM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define URM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: design/urm_pkg.sv
// Shared types, constants and saturation helper of the undistort-rectify map unit.
`timescale 1ns / 1ps
`default_nettype none

package urm_pkg;

  // Command codes of an input beat.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_MAP   = 1'b1
  } urm_cmd_e;

  // Coefficient store layout.
  localparam int NCOEF    = 22;
  localparam int IDX_RFX  = 0;
  localparam int IDX_RFY  = 1;
  localparam int IDX_RCX  = 2;
  localparam int IDX_RCY  = 3;
  localparam int IDX_SFX  = 4;
  localparam int IDX_SFY  = 5;
  localparam int IDX_SCX  = 6;
  localparam int IDX_SCY  = 7;
  localparam int IDX_K1   = 8;
  localparam int IDX_K2   = 9;
  localparam int IDX_P1   = 10;
  localparam int IDX_P2   = 11;
  localparam int IDX_K3   = 12;
  localparam int IDX_R00  = 13;
  localparam int IDX_R01  = 14;
  localparam int IDX_R02  = 15;
  localparam int IDX_R10  = 16;
  localparam int IDX_R11  = 17;
  localparam int IDX_R12  = 18;
  localparam int IDX_R20  = 19;
  localparam int IDX_R21  = 20;
  localparam int IDX_R22  = 21;

  // Configuration register indexes.
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  // Register stages of the divider, from operand capture to result.
  localparam int DIV_LAT = 35;

  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  // Saturated 32-bit value with its overflow mark.
  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat64(input logic signed [63:0] a);
    sat_t r;
    r.ovf = 1'b0;
    r.val = a[31:0];
    if (a > 64'(SMAX)) begin
      r.ovf = 1'b1;
      r.val = SMAX;
    end else if (a < 64'(SMIN)) begin
      r.ovf = 1'b1;
      r.val = SMIN;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/urm_div.sv
// Pipelined restoring divider: rounded fixed-point quotient, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module urm_div import urm_pkg::*; #(
  parameter int NUM_W     = 33,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic signed [31:0]      den_i,
  output logic signed [31:0]           quo_o,
  output logic                         ovf_o
);

  // Scaled dividend width and the part above the 32 quotient bits.
  localparam int NW2 = NUM_W + FRAC_BITS + 1;
  localparam int HW  = NW2 - 32;
  localparam int CW  = (HW > 32) ? HW : 32;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] quo;
    logic [31:0] lo;
    logic [31:0] ad;
    logic        neg;
    logic        dz;
    logic        npos;
    logic        nz;
    logic        big;
  } step_t;

  function automatic step_t div_step(input step_t s);
    step_t       r;
    logic [32:0] t;
    r = s;
    t = {s.rem[31:0], s.lo[31]};
    if (t >= {1'b0, s.ad}) begin
      r.rem = t - {1'b0, s.ad};
      r.quo = {s.quo[30:0], 1'b1};
    end else begin
      r.rem = t;
      r.quo = {s.quo[30:0], 1'b0};
    end
    r.lo = {s.lo[30:0], 1'b0};
    return r;
  endfunction

  logic [NUM_W-1:0] an;
  logic [31:0]      ad;
  logic [NW2-1:0]   n0_d, n0_q;
  logic [31:0]      ad0_q;
  logic             neg0_q, dz0_q, npos0_q, nz0_q;
  logic [HW-1:0]    hi;
  step_t            s1_d;
  step_t            step_q [0:32];
  step_t            fin;
  logic [32:0]      qc;
  logic signed [31:0] quo_d;
  logic             ovf_d;

  // Operand magnitudes and the rounding bias of half the divisor.
  always_comb begin
    an   = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    ad   = den_i[31] ? 32'(-den_i) : 32'(den_i);
    n0_d = (NW2'(an) << FRAC_BITS) + NW2'(ad >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n0_q    <= n0_d;
      ad0_q   <= ad;
      neg0_q  <= num_i[NUM_W-1] ^ den_i[31];
      dz0_q   <= (den_i == 32'sd0);
      npos0_q <= (num_i > NUM_W'(0)) && !num_i[NUM_W-1];
      nz0_q   <= (num_i == NUM_W'(0));
    end
  end

  // Overflow check and the initial partial remainder.
  always_comb begin
    hi       = n0_q[NW2-1:32];
    s1_d.rem = 33'(hi);
    s1_d.quo = '0;
    s1_d.lo  = n0_q[31:0];
    s1_d.ad  = ad0_q;
    s1_d.neg = neg0_q;
    s1_d.dz  = dz0_q;
    s1_d.npos = npos0_q;
    s1_d.nz  = nz0_q;
    s1_d.big = CW'(hi) >= CW'(ad0_q);
  end

  // One quotient bit per stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q[0] <= s1_d;
      for (int k = 1; k <= 32; k++) begin
        step_q[k] <= div_step(step_q[k-1]);
      end
    end
  end

  // Clamp, apply the sign and handle a zero divisor.
  always_comb begin
    fin   = step_q[32];
    qc    = (fin.big || (fin.quo > 32'h8000_0000)) ? 33'h0_8000_0000 : {1'b0, fin.quo};
    ovf_d = 1'b0;
    if (fin.dz) begin
      ovf_d = 1'b1;
      if (fin.npos) begin
        quo_d = SMAX;
      end else if (fin.nz) begin
        quo_d = '0;
      end else begin
        quo_d = SMIN;
      end
    end else if (!fin.neg && (qc == 33'h0_8000_0000)) begin
      ovf_d = 1'b1;
      quo_d = SMAX;
    end else if (fin.neg) begin
      quo_d = 32'(~qc + 33'd1);
    end else begin
      quo_d = qc[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= quo_d;
      ovf_o <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// File: design/undistort_rectify_map_unit.sv
// Top level of the undistort-rectify map unit: deep pipeline from rectified to source pixel.
//
//  Channel | Direction | Handshake                 | Beat contents
//  in      | sink      | in_valid_i / in_stall_o   | cmd, coef_index, coef_value, u_dst, v_dst
//  out     | source    | out_valid_o / out_stall_i | u_src, v_src, zero_depth, out_of_range,
//          |           |                           | overflowed
//  cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index, cfg_data
//
// One map beat is taken every cycle while no output stall holds the pipeline; its result leaves
// through the two 35-stage dividers and the multiply chain in between.
// A coefficient write waits until no map beat is in flight ahead of the output
// register, then is stored and gives no result.
// Reset clears the coefficient store, restores the map size and empties the pipeline.
// An output stall while a result is valid freezes every stage; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "undistort_rectify_map_unit_defines.svh"

module undistort_rectify_map_unit import urm_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  cmd_i,
  input  wire logic [4:0]            coef_index_i,
  input  wire logic signed [31:0]    coef_value_i,
  input  wire logic [COORD_BITS-1:0] u_dst_i,
  input  wire logic [COORD_BITS-1:0] v_dst_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [31:0]         u_src_o,
  output logic signed [31:0]         v_src_o,
  output logic                       zero_depth_o,
  output logic                       out_of_range_o,
  output logic                       overflowed_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic                  cfg_index_i,
  input  wire logic [12:0]           cfg_data_i
);

  // Numerator width of the back-projection division.
  localparam int NW = ((COORD_BITS + FRAC_BITS) > 32 ? COORD_BITS + FRAC_BITS : 32) + 1;

  // Stage positions along the pipeline.
  localparam int I_D1  = DIV_LAT;
  localparam int I_B1  = I_D1 + 1;
  localparam int I_B2  = I_D1 + 2;
  localparam int I_B3  = I_D1 + 3;
  localparam int I_D2  = I_B3 + DIV_LAT;
  localparam int I_OUT = I_D2 + 16;
  localparam int L     = I_OUT + 1;

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;

  function automatic sat_t rnd(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + HALF;
    return sat64(t >>> FRAC_BITS);
  endfunction

  function automatic logic signed [63:0] mul(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  // ---------------------------------------------------------------- control
  logic signed [31:0] coef_q [NCOEF];
  logic [12:0]        map_w_q, map_h_q;
  logic [L-1:0]       v_q, oor_q, zd_q, fl_q;
  logic [L-1:0]       add_fl, add_zd;
  logic               adv, busy, in_acc, oor_new;

  assign adv         = !v_q[I_OUT] || !out_stall_i;
  assign busy        = |v_q[I_OUT-1:0];
  assign in_stall_o  = !adv || (in_valid_i && (cmd_i == CMD_WRITE) && busy);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign oor_new     = (16'(u_dst_i) >= 16'(map_w_q)) || (16'(v_dst_i) >= 16'(map_h_q));

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q <= 13'd640;
      map_h_q <= 13'd480;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MAP_WIDTH:  map_w_q <= cfg_data_i;
        REG_MAP_HEIGHT: map_h_q <= cfg_data_i;
        default:        map_w_q <= map_w_q;
      endcase
    end
  end

  // Coefficient store; indexes past the end are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_q[i] <= '0;
      end
    end else if (in_acc && (cmd_i == CMD_WRITE) && (coef_index_i < 5'(NCOEF))) begin
      coef_q[coef_index_i] <= coef_value_i;
    end
  end

  // Valid, range, zero-depth and overflow marks travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      oor_q <= '0;
      zd_q  <= '0;
      fl_q  <= '0;
    end else if (adv) begin
      v_q   <= {v_q[L-2:0], in_valid_i && (cmd_i == CMD_MAP) && !in_stall_o};
      oor_q <= {oor_q[L-2:0], oor_new};
      zd_q  <= {zd_q[L-2:0], 1'b0} | add_zd;
      fl_q  <= {fl_q[L-2:0], 1'b0} | add_fl;
    end
  end

  // ---------------------------------------------------------------- back-projection
  logic signed [NW-1:0] nx_q, ny_q;
  logic signed [31:0]   dxr, dyr, dx, dy;
  logic                 dxr_ovf, dyr_ovf, dx_ovf, dy_ovf;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q <= (NW'(u_dst_i) << FRAC_BITS) - NW'(coef_q[IDX_RCX]);
      ny_q <= (NW'(v_dst_i) << FRAC_BITS) - NW'(coef_q[IDX_RCY]);
    end
  end

  urm_div #(.NUM_W(NW), .FRAC_BITS(FRAC_BITS)) u_div_xr (
    .clk_i(clk_i), .en_i(adv), .num_i(nx_q), .den_i(coef_q[IDX_RFX]),
    .quo_o(dxr), .ovf_o(dxr_ovf)
  );

  urm_div #(.NUM_W(NW), .FRAC_BITS(FRAC_BITS)) u_div_yr (
    .clk_i(clk_i), .en_i(adv), .num_i(ny_q), .den_i(coef_q[IDX_RFY]),
    .quo_o(dyr), .ovf_o(dyr_ovf)
  );

  // ---------------------------------------------------------------- rotation
  logic signed [63:0] b1_q [6];
  logic signed [31:0] b2_q [6];
  sat_t               b2_r [6];
  logic signed [31:0] xs_q, ys_q, zs_q;
  sat_t               xs_s, ys_s, zs_s;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      b2_r[i] = rnd(b1_q[i]);
    end
    xs_s = sat64(64'(b2_q[0]) + 64'(b2_q[1]) + 64'(coef_q[IDX_R20]));
    ys_s = sat64(64'(b2_q[2]) + 64'(b2_q[3]) + 64'(coef_q[IDX_R21]));
    zs_s = sat64(64'(b2_q[4]) + 64'(b2_q[5]) + 64'(coef_q[IDX_R22]));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_q[0] <= mul(coef_q[IDX_R00], dxr);
      b1_q[1] <= mul(coef_q[IDX_R10], dyr);
      b1_q[2] <= mul(coef_q[IDX_R01], dxr);
      b1_q[3] <= mul(coef_q[IDX_R11], dyr);
      b1_q[4] <= mul(coef_q[IDX_R02], dxr);
      b1_q[5] <= mul(coef_q[IDX_R12], dyr);
      for (int i = 0; i < 6; i++) begin
        b2_q[i] <= b2_r[i].val;
      end
      xs_q <= xs_s.val;
      ys_q <= ys_s.val;
      zs_q <= zs_s.val;
    end
  end

  urm_div #(.NUM_W(32), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i(clk_i), .en_i(adv), .num_i(xs_q), .den_i(zs_q),
    .quo_o(dx), .ovf_o(dx_ovf)
  );

  urm_div #(.NUM_W(32), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i(clk_i), .en_i(adv), .num_i(ys_q), .den_i(zs_q),
    .quo_o(dy), .ovf_o(dy_ovf)
  );

  // ---------------------------------------------------------------- distortion
  logic signed [63:0] xx1_q, yy1_q, xy1_q;
  logic signed [31:0] xc_q [1:10];
  logic signed [31:0] yc_q [1:10];
  logic signed [31:0] mxx2_q, myy2_q, mxy2_q;
  logic signed [31:0] r2_3_q, mxx3_q, myy3_q;
  logic signed [63:0] pa3_q, pb3_q;
  logic signed [31:0] tx4_q, ty4_q;
  logic signed [63:0] r44_q;
  logic signed [31:0] p1xy_q [4:12];
  logic signed [31:0] p2xy_q [4:12];
  logic signed [31:0] r2c_q [4:5];
  logic signed [31:0] r4_5_q;
  logic signed [63:0] ptx5_q, pty5_q;
  logic signed [63:0] r6r_q, k1r_q, k2r_q;
  logic signed [31:0] p2tx_q [6:12];
  logic signed [31:0] p1ty_q [6:12];
  logic signed [31:0] r6_7_q, k1r2_7_q, k2r4_7_q;
  logic signed [63:0] k3r_q, s12_8_q, s12_9_q;
  logic signed [31:0] k3r6_q, rad_q;
  logic signed [63:0] xrad_q, yrad_q;
  logic signed [31:0] mxrad_q, myrad_q, xd_q, yd_q;
  logic signed [63:0] fxr_q, fyr_q;
  logic signed [31:0] mfx_q, mfy_q, us_q, vs_q;

  sat_t c2_xx, c2_yy, c2_xy, c3_r2, c4_tx, c4_ty, c4_pa, c4_pb;
  sat_t c5_r4, c6_tx, c6_ty, c7_r6, c7_k1, c7_k2, c9_k3, c10_rad;
  sat_t c12_x, c12_y, c13_xd, c13_yd, c15_x, c15_y, c16_u, c16_v;

  // Rounding and saturation between the product registers.
  always_comb begin
    c2_xx   = rnd(xx1_q);
    c2_yy   = rnd(yy1_q);
    c2_xy   = rnd(xy1_q);
    c3_r2   = sat64(64'(mxx2_q) + 64'(myy2_q));
    c4_tx   = sat64(64'(r2_3_q) + (64'(mxx3_q) <<< 1));
    c4_ty   = sat64(64'(r2_3_q) + (64'(myy3_q) <<< 1));
    c4_pa   = rnd(pa3_q);
    c4_pb   = rnd(pb3_q);
    c5_r4   = rnd(r44_q);
    c6_tx   = rnd(ptx5_q);
    c6_ty   = rnd(pty5_q);
    c7_r6   = rnd(r6r_q);
    c7_k1   = rnd(k1r_q);
    c7_k2   = rnd(k2r_q);
    c9_k3   = rnd(k3r_q);
    c10_rad = sat64(ONE + s12_9_q + 64'(k3r6_q));
    c12_x   = rnd(xrad_q);
    c12_y   = rnd(yrad_q);
    c13_xd  = sat64(64'(mxrad_q) + (64'(p1xy_q[12]) <<< 1) + 64'(p2tx_q[12]));
    c13_yd  = sat64(64'(myrad_q) + 64'(p1ty_q[12]) + (64'(p2xy_q[12]) <<< 1));
    c15_x   = rnd(fxr_q);
    c15_y   = rnd(fyr_q);
    c16_u   = sat64(64'(mfx_q) + 64'(coef_q[IDX_SCX]));
    c16_v   = sat64(64'(mfy_q) + 64'(coef_q[IDX_SCY]));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xx1_q    <= mul(dx, dx);
      yy1_q    <= mul(dy, dy);
      xy1_q    <= mul(dx, dy);
      xc_q[1]  <= dx;
      yc_q[1]  <= dy;
      for (int k = 2; k <= 10; k++) begin
        xc_q[k] <= xc_q[k-1];
        yc_q[k] <= yc_q[k-1];
      end
      mxx2_q   <= c2_xx.val;
      myy2_q   <= c2_yy.val;
      mxy2_q   <= c2_xy.val;
      r2_3_q   <= c3_r2.val;
      mxx3_q   <= mxx2_q;
      myy3_q   <= myy2_q;
      pa3_q    <= mul(coef_q[IDX_P1], mxy2_q);
      pb3_q    <= mul(coef_q[IDX_P2], mxy2_q);
      tx4_q    <= c4_tx.val;
      ty4_q    <= c4_ty.val;
      r44_q    <= mul(r2_3_q, r2_3_q);
      p1xy_q[4] <= c4_pa.val;
      p2xy_q[4] <= c4_pb.val;
      for (int k = 5; k <= 12; k++) begin
        p1xy_q[k] <= p1xy_q[k-1];
        p2xy_q[k] <= p2xy_q[k-1];
      end
      r2c_q[4] <= r2_3_q;
      r2c_q[5] <= r2c_q[4];
      r4_5_q   <= c5_r4.val;
      ptx5_q   <= mul(coef_q[IDX_P2], tx4_q);
      pty5_q   <= mul(coef_q[IDX_P1], ty4_q);
      r6r_q    <= mul(r4_5_q, r2c_q[5]);
      k1r_q    <= mul(coef_q[IDX_K1], r2c_q[5]);
      k2r_q    <= mul(coef_q[IDX_K2], r4_5_q);
      p2tx_q[6] <= c6_tx.val;
      p1ty_q[6] <= c6_ty.val;
      for (int k = 7; k <= 12; k++) begin
        p2tx_q[k] <= p2tx_q[k-1];
        p1ty_q[k] <= p1ty_q[k-1];
      end
      r6_7_q   <= c7_r6.val;
      k1r2_7_q <= c7_k1.val;
      k2r4_7_q <= c7_k2.val;
      k3r_q    <= mul(coef_q[IDX_K3], r6_7_q);
      s12_8_q  <= 64'(k1r2_7_q) + 64'(k2r4_7_q);
      k3r6_q   <= c9_k3.val;
      s12_9_q  <= s12_8_q;
      rad_q    <= c10_rad.val;
      xrad_q   <= mul(xc_q[10], rad_q);
      yrad_q   <= mul(yc_q[10], rad_q);
      mxrad_q  <= c12_x.val;
      myrad_q  <= c12_y.val;
      xd_q     <= c13_xd.val;
      yd_q     <= c13_yd.val;
      fxr_q    <= mul(coef_q[IDX_SFX], xd_q);
      fyr_q    <= mul(coef_q[IDX_SFY], yd_q);
      mfx_q    <= c15_x.val;
      mfy_q    <= c15_y.val;
      // A zero depth forces both positions to the positive limit.
      us_q     <= zd_q[I_OUT-1] ? SMAX : c16_u.val;
      vs_q     <= zd_q[I_OUT-1] ? SMAX : c16_v.val;
    end
  end

  // Saturation marks enter the flag line at the stage that produced them.
  always_comb begin
    add_fl = '0;
    add_zd = '0;
    add_fl[I_B1]    = dxr_ovf || dyr_ovf;
    add_fl[I_B2]    = b2_r[0].ovf || b2_r[1].ovf || b2_r[2].ovf
                      || b2_r[3].ovf || b2_r[4].ovf || b2_r[5].ovf;
    add_fl[I_B3]    = xs_s.ovf || ys_s.ovf || zs_s.ovf;
    add_zd[I_B3+1]  = (zs_q == 32'sd0);
    add_fl[I_D2+1]  = dx_ovf || dy_ovf;
    add_fl[I_D2+2]  = c2_xx.ovf || c2_yy.ovf || c2_xy.ovf;
    add_fl[I_D2+3]  = c3_r2.ovf;
    add_fl[I_D2+4]  = c4_tx.ovf || c4_ty.ovf || c4_pa.ovf || c4_pb.ovf;
    add_fl[I_D2+5]  = c5_r4.ovf;
    add_fl[I_D2+6]  = c6_tx.ovf || c6_ty.ovf;
    add_fl[I_D2+7]  = c7_r6.ovf || c7_k1.ovf || c7_k2.ovf;
    add_fl[I_D2+9]  = c9_k3.ovf;
    add_fl[I_D2+10] = c10_rad.ovf;
    add_fl[I_D2+12] = c12_x.ovf || c12_y.ovf;
    add_fl[I_D2+13] = c13_xd.ovf || c13_yd.ovf;
    add_fl[I_D2+15] = c15_x.ovf || c15_y.ovf;
    add_fl[I_OUT]   = c16_u.ovf || c16_v.ovf;
  end

  // ---------------------------------------------------------------- result beat
  assign out_valid_o    = v_q[I_OUT];
  assign u_src_o        = us_q;
  assign v_src_o        = vs_q;
  assign zero_depth_o   = zd_q[I_OUT];
  assign out_of_range_o = oor_q[I_OUT];
  assign overflowed_o   = fl_q[I_OUT] || zd_q[I_OUT];

  // ---------------------------------------------------------------- checks
  `URM_ASSERT(a_write_when_empty, clk_i, rst_ni, (in_acc && (cmd_i == CMD_WRITE)) |-> !busy, "coefficient write taken with beats in flight")
  `URM_ASSERT(a_freeze_on_stall, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> $stable(v_q), "pipeline moved while the output was stalled")
  `URM_ASSERT(a_map_enters, clk_i, rst_ni, (in_acc && (cmd_i == CMD_MAP)) |=> v_q[0], "accepted map beat did not enter the pipeline")
  `URM_ASSERT_NR(a_zero_depth_sat, clk_i, (out_valid_o && zero_depth_o) |-> (overflowed_o && (u_src_o == SMAX) && (v_src_o == SMAX)), "zero depth without saturated result")

endmodule

`default_nettype wire
